// ===== hw/rtl/b2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b2r_pkg;

  // Result status codes
  localparam logic [2:0] ST_PIXEL     = 3'd0;
  localparam logic [2:0] ST_OFFSCREEN = 3'd1;
  localparam logic [2:0] ST_NOT_BMP   = 3'd2;
  localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X      = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y      = 2'd1;
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

  localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd320;
  localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd240;

  // Result queue between parser and formatter
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] screen_width;
    logic [15:0] screen_height;
  } cfg_t;

  // One result as the parser leaves it: raw color bytes, column, row counted down from the top
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] col;
    logic [15:0] row_down;
    logic        last;
  } rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/b2r_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b2r_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire b2r_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    file_byte,
  input  wire logic          first_byte,
  output logic               push_valid,
  output b2r_pkg::rec_t      push_data,
  input  wire logic          push_ready
);
  import b2r_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_PIXEL  = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  localparam logic [4:0] POS_SIG_B   = 5'd0;
  localparam logic [4:0] POS_SIG_M   = 5'd1;
  localparam logic [4:0] POS_OFS0    = 5'd10;
  localparam logic [4:0] POS_OFS1    = 5'd11;
  localparam logic [4:0] POS_OFS2    = 5'd12;
  localparam logic [4:0] POS_OFS3    = 5'd13;
  localparam logic [4:0] POS_WID0    = 5'd18;
  localparam logic [4:0] POS_WID1    = 5'd19;
  localparam logic [4:0] POS_WID2    = 5'd20;
  localparam logic [4:0] POS_WID3    = 5'd21;
  localparam logic [4:0] POS_HGT0    = 5'd22;
  localparam logic [4:0] POS_HGT1    = 5'd23;
  localparam logic [4:0] POS_HGT2    = 5'd24;
  localparam logic [4:0] POS_HGT3    = 5'd25;
  localparam logic [4:0] POS_DEPTH   = 5'd28;
  localparam logic [7:0] SIG_B       = 8'h42;
  localparam logic [7:0] SIG_M       = 8'h4D;
  localparam logic [7:0] DEPTH_24    = 8'd24;
  localparam logic [31:0] MIN_OFFSET = 32'd29;

  phase_t      phase, phase_eff, phase_next;
  logic [31:0] pos, pos_eff, pos_next;
  logic [31:0] offset, offset_eff, offset_next;
  logic [15:0] width, width_eff, width_next;
  logic [15:0] height, height_eff, height_next;
  logic [15:0] col, col_eff, col_next;
  logic [15:0] row_down, row_down_eff, row_down_next;
  logic [1:0]  bip, bip_eff, bip_next;
  logic [7:0]  blue, blue_eff, blue_next;
  logic [7:0]  green, green_eff, green_next;
  logic [1:0]  pad, pad_eff, pad_next;
  logic        big, big_eff, big_next;
  logic        emit;
  logic        err;
  logic [2:0]  err_code;
  logic [15:0] col_inc;
  logic [4:0]  hpos;
  logic        accept;
  rec_t        rec;

  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  assign push_valid = accept && emit;
  assign push_data  = rec;

  always_comb begin
    // first_byte restarts the parse before the byte itself is handled
    phase_eff    = phase;
    pos_eff      = pos;
    offset_eff   = offset;
    width_eff    = width;
    height_eff   = height;
    col_eff      = col;
    row_down_eff = row_down;
    bip_eff      = bip;
    blue_eff     = blue;
    green_eff    = green;
    pad_eff      = pad;
    big_eff      = big;
    err          = 1'b0;
    err_code     = ST_PIXEL;
    emit         = 1'b0;
    rec          = '0;
    if (first_byte) begin
      phase_eff    = PH_HEADER;
      pos_eff      = '0;
      offset_eff   = '0;
      width_eff    = '0;
      height_eff   = '0;
      col_eff      = '0;
      row_down_eff = '0;
      bip_eff      = '0;
      blue_eff     = '0;
      green_eff    = '0;
      pad_eff      = '0;
      big_eff      = 1'b0;
      if (cfg.origin_x >= cfg.screen_width || cfg.origin_y >= cfg.screen_height) begin
        phase_eff = PH_DONE;
        err       = 1'b1;
        err_code  = ST_OFFSCREEN;
      end
    end

    phase_next    = phase_eff;
    pos_next      = pos_eff;
    offset_next   = offset_eff;
    width_next    = width_eff;
    height_next   = height_eff;
    col_next      = col_eff;
    row_down_next = row_down_eff;
    bip_next      = bip_eff;
    blue_next     = blue_eff;
    green_next    = green_eff;
    pad_next      = pad_eff;
    big_next      = big_eff;
    hpos          = pos_eff[4:0];
    col_inc       = col_eff + 16'd1;

    case (phase_eff)
      PH_HEADER: begin
        pos_next = pos_eff + 32'd1;
        case (hpos)
          POS_SIG_B: begin
            if (file_byte != SIG_B) begin
              err      = 1'b1;
              err_code = ST_NOT_BMP;
            end
          end
          POS_SIG_M: begin
            if (file_byte != SIG_M) begin
              err      = 1'b1;
              err_code = ST_NOT_BMP;
            end
          end
          POS_OFS0: offset_next[7:0]   = file_byte;
          POS_OFS1: offset_next[15:8]  = file_byte;
          POS_OFS2: offset_next[23:16] = file_byte;
          POS_OFS3: offset_next[31:24] = file_byte;
          POS_WID0: width_next[7:0]    = file_byte;
          POS_WID1: width_next[15:8]   = file_byte;
          POS_HGT0: height_next[7:0]   = file_byte;
          POS_HGT1: height_next[15:8]  = file_byte;
          POS_WID2, POS_WID3, POS_HGT2, POS_HGT3: begin
            if (file_byte != 8'd0) big_next = 1'b1;
          end
          POS_DEPTH: begin
            if (file_byte != DEPTH_24) begin
              err      = 1'b1;
              err_code = ST_BAD_DEPTH;
            end else if (big_eff) begin
              err      = 1'b1;
              err_code = ST_TOO_LARGE;
            end else if (offset_eff < MIN_OFFSET) begin
              err      = 1'b1;
              err_code = ST_BAD_OFFSET;
            end else if (width_eff == 16'd0 || height_eff == 16'd0) begin
              phase_next = PH_DONE;
            end else begin
              row_down_next = height_eff - 16'd1;
              if (pos_next == offset_eff) phase_next = PH_PIXEL;
              else phase_next = PH_SKIP;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        pos_next = pos_eff + 32'd1;
        if (pos_next == offset_eff) phase_next = PH_PIXEL;
      end
      PH_PIXEL: begin
        case (bip_eff)
          2'd0: begin
            blue_next = file_byte;
            bip_next  = 2'd1;
          end
          2'd1: begin
            green_next = file_byte;
            bip_next   = 2'd2;
          end
          default: begin
            bip_next     = 2'd0;
            emit         = 1'b1;
            rec.status   = ST_PIXEL;
            rec.red      = file_byte;
            rec.green    = green_eff;
            rec.blue     = blue_eff;
            rec.col      = col_eff;
            rec.row_down = row_down_eff;
            rec.last     = (row_down_eff == 16'd0) && (col_inc == width_eff);
            col_next     = col_inc;
            if (col_inc == width_eff) begin
              pad_next = width_eff[1:0];
              if (width_eff[1:0] == 2'd0) begin
                // end of row
                col_next = '0;
                if (row_down_eff == 16'd0) phase_next = PH_DONE;
                else row_down_next = row_down_eff - 16'd1;
              end else begin
                phase_next = PH_PAD;
              end
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_next = pad_eff - 2'd1;
        if (pad_next == 2'd0) begin
          col_next = '0;
          if (row_down_eff == 16'd0) begin
            phase_next = PH_DONE;
          end else begin
            row_down_next = row_down_eff - 16'd1;
            phase_next    = PH_PIXEL;
          end
        end
      end
      default: ;
    endcase

    if (err) begin
      phase_next = PH_DONE;
      emit       = 1'b1;
      rec        = '0;
      rec.status = err_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos      <= pos_next;
      offset   <= offset_next;
      width    <= width_next;
      height   <= height_next;
      col      <= col_next;
      row_down <= row_down_next;
      bip      <= bip_next;
      blue     <= blue_next;
      green    <= green_next;
      pad      <= pad_next;
      big      <= big_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b2r_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b2r_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire b2r_pkg::rec_t push_data,
  output logic               push_ready,
  output logic               pop_valid,
  output b2r_pkg::rec_t      pop_data,
  input  wire logic          pop_ready
);
  import b2r_pkg::*;

  rec_t           mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != (QAw+1)'(QDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QAw'(1);
      if (do_pop) rd_ptr <= rd_ptr + QAw'(1);
      if (do_push && !do_pop) count <= count + (QAw+1)'(1);
      else if (do_pop && !do_push) count <= count - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b2r_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b2r_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [15:0]   origin_x,
  input  wire logic [15:0]   origin_y,
  input  wire logic          pop_valid,
  input  wire b2r_pkg::rec_t pop_data,
  output logic               pop_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         status,
  output logic [15:0]        color565,
  output logic [16:0]        screen_x,
  output logic [16:0]        screen_y,
  output logic               last_pixel
);
  import b2r_pkg::*;

  logic is_pixel;

  assign pop_ready = !out_valid || out_ready;
  assign is_pixel  = (pop_data.status == ST_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  // Error results carry zeros in every field but status
  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      status <= pop_data.status;
      if (is_pixel) begin
        color565   <= {pop_data.red[7:3], pop_data.green[7:2], pop_data.blue[7:3]};
        screen_x   <= {1'b0, origin_x} + {1'b0, pop_data.col};
        screen_y   <= {1'b0, origin_y} + {1'b0, pop_data.row_down};
        last_pixel <= pop_data.last;
      end else begin
        color565   <= '0;
        screen_x   <= '0;
        screen_y   <= '0;
        last_pixel <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmp24_to_rgb565_stream_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming 24-bit BMP to RGB565 decoder. Feed the file one byte per
// transaction on the input channel, with first_byte high on byte zero; that
// byte restarts parsing and checks the origin against the screen size. The
// block checks the "BM" signature, collects the pixel offset, width and height
// from the header, requires a depth of 24, skips to the pixel data and emits
// one result per B,G,R triple: color565 plus screen_x/screen_y, with rows
// placed bottom-up and last_pixel on the final pixel. Row padding and trailing
// bytes produce nothing. An error gives one result with a nonzero status and
// zeroed fields, after which the file is ignored until the next first_byte.
// Rate: one byte per cycle, sustained, as long as results are taken. The
// header parser in the front updates its state once per byte; a four-entry
// result queue and the output register of the formatter let the front keep
// taking bytes while a result waits. A result is queued, then registered.
// Write configuration only while the block is idle.

module bmp24_to_rgb565_stream_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  file_byte,
  input  wire logic        first_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [15:0]      color565,
  output logic [16:0]      screen_x,
  output logic [16:0]      screen_y,
  output logic             last_pixel
);
  import b2r_pkg::*;

  cfg_t cfg;
  logic push_valid;
  rec_t push_data;
  logic push_ready;
  logic pop_valid;
  rec_t pop_data;
  logic pop_ready;

  // Configuration registers, one write per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:      cfg.origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      cfg.origin_y      <= cfg_data;
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: parse the byte stream and classify each byte
  b2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .file_byte  (file_byte),
    .first_byte (first_byte),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Queue: hold pending results so each side can stall on its own
  b2r_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // Back: pack the color, place the pixel on screen, register the result
  b2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .origin_x   (cfg.origin_x),
    .origin_y   (cfg.origin_y),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .color565   (color565),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire
